// File: design/ssd_pkg.sv
`default_nettype none
package ssd_pkg;

	// default coordinate width of the input fields
	localparam int SSD_COORD_BITS_DEF = 16;

	// result field width and saturation value
	localparam int DIST_W = 17;
	localparam logic [DIST_W-1:0] DIST_MAX = 17'h1ffff;

	// lane count: four point-to-segment distances per item
	localparam int LANES = 4;

	// sign of a cross product, exported early for the crossing test
	typedef struct packed {
		logic pos;
		logic neg;
	} ssd_sign_t;

	// squared-value width for a given coordinate width
	function automatic int ssd_sq_w(input int c);
		return 2 * c + 3;
	endfunction

	// root width for a given coordinate width
	function automatic int ssd_root_w(input int c);
		return c + 2;
	endfunction

	// cycles from lane input to lane result
	function automatic int ssd_lane_lat(input int c);
		return 4 + ssd_sq_w(c) + ssd_root_w(c);
	endfunction

endpackage
`default_nettype wire

// File: design/ssd_div.sv
`default_nettype none
module ssd_div import ssd_pkg::*; #(
	parameter int VW = 35,
	parameter int SDW = 36
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_in,
	input  wire logic [2*VW-1:0]   num,
	input  wire logic [VW-1:0]     den,
	input  wire logic [SDW-1:0]    side_in,
	output logic                   valid_out,
	output logic [VW-1:0]          quo,
	output logic [SDW-1:0]         side_out
);

	// restoring division, one quotient bit per stage
	localparam int NW = 2 * VW;

	logic [VW-1:0]  rem_s  [VW];
	logic [VW-1:0]  low_s  [VW];
	logic [VW-1:0]  quo_s  [VW];
	logic [VW-1:0]  den_s  [VW];
	logic [SDW-1:0] side_s [VW];
	logic           vld_s  [VW];

	for (genvar k = 0; k < VW; k++) begin : g_st
		logic [VW-1:0]  rem_i;
		logic [VW-1:0]  low_i;
		logic [VW-1:0]  quo_i;
		logic [VW-1:0]  den_i;
		logic [SDW-1:0] side_i;
		logic           vld_i;
		logic [VW:0]    trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_i  = num[NW-1:VW];
			assign low_i  = num[VW-1:0];
			assign quo_i  = '0;
			assign den_i  = den;
			assign side_i = side_in;
			assign vld_i  = valid_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign low_i  = low_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign den_i  = den_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign trial = {rem_i, low_i[VW-1]};
		assign ge    = trial >= {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? VW'(trial - {1'b0, den_i}) : trial[VW-1:0];
			low_s[k]  <= {low_i[VW-2:0], 1'b0};
			quo_s[k]  <= {quo_i[VW-2:0], ge};
			den_s[k]  <= den_i;
			side_s[k] <= side_i;
		end
	end

	assign valid_out = vld_s[VW-1];
	assign quo       = quo_s[VW-1];
	assign side_out  = side_s[VW-1];

endmodule
`default_nettype wire

// File: design/ssd_isqrt.sv
`default_nettype none
module ssd_isqrt import ssd_pkg::*; #(
	parameter int RW = 18
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_in,
	input  wire logic [2*RW-1:0]  val,
	output logic                  valid_out,
	output logic [RW-1:0]         root
);

	// digit-by-digit floor square root, one root bit per stage
	localparam int VLW = 2 * RW;
	localparam int RMW = RW + 2;

	logic [RMW-1:0] rem_s  [RW];
	logic [RW-1:0]  root_s [RW];
	logic [VLW-1:0] val_s  [RW];
	logic           vld_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_st
		logic [RMW-1:0] rem_i;
		logic [RW-1:0]  root_i;
		logic [VLW-1:0] val_i;
		logic           vld_i;
		logic [RMW+1:0] trial_rem;
		logic [RMW+1:0] trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_i  = '0;
			assign root_i = '0;
			assign val_i  = val;
			assign vld_i  = valid_in;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
			assign val_i  = val_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		assign trial_rem = {rem_i, val_i[VLW-1:VLW-2]};
		assign trial     = (RMW+2)'({root_i, 2'b01});
		assign ge        = trial_rem >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? RMW'(trial_rem - trial) : trial_rem[RMW-1:0];
			root_s[k] <= {root_i[RW-2:0], ge};
			val_s[k]  <= {val_i[VLW-3:0], 2'b00};
		end
	end

	assign valid_out = vld_s[RW-1];
	assign root      = root_s[RW-1];

endmodule
`default_nettype wire

// File: design/ssd_lane.sv
`default_nettype none
module ssd_lane import ssd_pkg::*; #(
	parameter int COORD_BITS = SSD_COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         valid_in,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	input  wire logic signed [COORD_BITS-1:0] cx,
	input  wire logic signed [COORD_BITS-1:0] cy,
	output ssd_sign_t                         cr_sign,
	output logic                              valid_out,
	output logic [COORD_BITS+1:0]             seg_dist
);

	// floor distance from point c to segment a-b
	localparam int DFW = COORD_BITS + 1;
	localparam int PW  = 2 * COORD_BITS + 3;
	localparam int SW  = PW + 1;
	localparam int VW  = ssd_sq_w(COORD_BITS);
	localparam int AW  = VW;
	localparam int NW  = 2 * AW;
	localparam int H   = (AW + 1) / 2;
	localparam int HW  = AW - H;
	localparam int RW  = ssd_root_w(COORD_BITS);
	localparam int SDW = VW + 1;

	// stage 1: coordinate differences
	logic signed [DFW-1:0] bax_s1, bay_s1, cax_s1, cay_s1, cbx_s1, cby_s1;
	logic                  valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		bax_s1 <= DFW'(bx) - DFW'(ax);
		bay_s1 <= DFW'(by) - DFW'(ay);
		cax_s1 <= DFW'(cx) - DFW'(ax);
		cay_s1 <= DFW'(cy) - DFW'(ay);
		cbx_s1 <= DFW'(cx) - DFW'(bx);
		cby_s1 <= DFW'(cy) - DFW'(by);
	end

	// stage 2: dot products, cross product, squared lengths
	logic signed [SW-1:0] dotb_s2, dota_s2, cr_s2;
	logic [VW-1:0]        len_s2, db2_s2, da2_s2;
	logic                 valid_s2;
	logic signed [SW-1:0] len_w, db2_w, da2_w;

	assign len_w = SW'(PW'(bax_s1) * PW'(bax_s1)) + SW'(PW'(bay_s1) * PW'(bay_s1));
	assign db2_w = SW'(PW'(cbx_s1) * PW'(cbx_s1)) + SW'(PW'(cby_s1) * PW'(cby_s1));
	assign da2_w = SW'(PW'(cax_s1) * PW'(cax_s1)) + SW'(PW'(cay_s1) * PW'(cay_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dotb_s2 <= SW'(PW'(bax_s1) * PW'(cbx_s1)) + SW'(PW'(bay_s1) * PW'(cby_s1));
		dota_s2 <= SW'(PW'(bax_s1) * PW'(cax_s1)) + SW'(PW'(bay_s1) * PW'(cay_s1));
		cr_s2   <= SW'(PW'(bax_s1) * PW'(cay_s1)) - SW'(PW'(bay_s1) * PW'(cax_s1));
		len_s2  <= len_w[VW-1:0];
		db2_s2  <= db2_w[VW-1:0];
		da2_s2  <= da2_w[VW-1:0];
	end

	assign cr_sign.pos = !cr_s2[SW-1] && (cr_s2 != '0);
	assign cr_sign.neg = cr_s2[SW-1];

	// stage 3: end test, partial squares of the cross product
	logic [AW-1:0]   crabs;
	logic            sel_b, sel_a;
	logic            perp_s3, valid_s3;
	logic [VW-1:0]   e2_s3, len_s3;
	logic [2*HW-1:0] hi2_s3;
	logic [AW-1:0]   hl_s3;
	logic [2*H-1:0]  lo2_s3;

	assign crabs = cr_s2[SW-1] ? AW'(-cr_s2) : AW'(cr_s2);
	// foot beyond end b, else beyond end a
	assign sel_b = !dotb_s2[SW-1];
	assign sel_a = dota_s2[SW-1] || (dota_s2 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		perp_s3 <= !sel_b && !sel_a;
		e2_s3   <= sel_b ? db2_s2 : da2_s2;
		len_s3  <= len_s2;
		hi2_s3  <= (2*HW)'(crabs[AW-1:H]) * (2*HW)'(crabs[AW-1:H]);
		hl_s3   <= AW'(crabs[AW-1:H]) * AW'(crabs[H-1:0]);
		lo2_s3  <= (2*H)'(crabs[H-1:0]) * (2*H)'(crabs[H-1:0]);
	end

	// stage 4: cross product squared
	logic [NW-1:0] c2_s4;
	logic [VW-1:0] e2_s4, len_s4;
	logic          perp_s4, valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		c2_s4   <= (NW'(hi2_s3) << (2 * H)) + (NW'(hl_s3) << (H + 1)) + NW'(lo2_s3);
		e2_s4   <= e2_s3;
		len_s4  <= len_s3;
		perp_s4 <= perp_s3;
	end

	// cross^2 / len^2, then the root of whichever square applies
	logic            dv_valid;
	logic [VW-1:0]   dv_quo;
	logic [SDW-1:0]  dv_side;
	logic [VW-1:0]   sq_val;

	ssd_div #(.VW(VW), .SDW(SDW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (valid_s4),
		.num      (c2_s4),
		.den      (len_s4),
		.side_in  ({perp_s4, e2_s4}),
		.valid_out(dv_valid),
		.quo      (dv_quo),
		.side_out (dv_side)
	);

	assign sq_val = dv_side[SDW-1] ? dv_quo : dv_side[VW-1:0];

	ssd_isqrt #(.RW(RW)) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_in (dv_valid),
		.val      ((2*RW)'(sq_val)),
		.valid_out(valid_out),
		.root     (seg_dist)
	);

endmodule
`default_nettype wire

// File: design/segment_to_segment_distance_core.sv
`default_nettype none
// Least distance between two 2-D segments, floored to whole grid units.
// An item is taken on every clock edge where start is high; busy is always
// low because the pipeline never stalls. Each item yields one result, shown
// for one cycle with done high, after it has passed four setup stages, one
// restoring-divider stage per quotient bit (2*COORD_BITS+3), one square-root
// stage per root bit (COORD_BITS+2), and two stages for the minimum. Results
// come out in order and the receiver cannot hold them off, so it must take
// one per cycle. Properly crossing segments give min_distance 0 and
// crossing 1. Distances above 131071 saturate.
module segment_to_segment_distance_core import ssd_pkg::*; #(
	parameter int COORD_BITS = SSD_COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] seg_a_start_x,
	input  wire logic signed [COORD_BITS-1:0] seg_a_start_y,
	input  wire logic signed [COORD_BITS-1:0] seg_a_end_x,
	input  wire logic signed [COORD_BITS-1:0] seg_a_end_y,
	input  wire logic signed [COORD_BITS-1:0] seg_b_start_x,
	input  wire logic signed [COORD_BITS-1:0] seg_b_start_y,
	input  wire logic signed [COORD_BITS-1:0] seg_b_end_x,
	input  wire logic signed [COORD_BITS-1:0] seg_b_end_y,
	output logic                              done,
	output logic [DIST_W-1:0]                 min_distance,
	output logic                              crossing
);

	localparam int RW = ssd_root_w(COORD_BITS);
	localparam int LL = ssd_lane_lat(COORD_BITS);
	localparam int CDL = LL - 2;
	localparam int WW = (RW > DIST_W) ? RW : DIST_W;

	// no back-pressure anywhere in the pipeline
	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// lane c-points and segments:
	//   lane 0: a start vs seg b   lane 1: a end vs seg b
	//   lane 2: b start vs seg a   lane 3: b end vs seg a
	// the lane cross products double as the four orientation tests
	logic signed [COORD_BITS-1:0] ln_ax [LANES];
	logic signed [COORD_BITS-1:0] ln_ay [LANES];
	logic signed [COORD_BITS-1:0] ln_bx [LANES];
	logic signed [COORD_BITS-1:0] ln_by [LANES];
	logic signed [COORD_BITS-1:0] ln_cx [LANES];
	logic signed [COORD_BITS-1:0] ln_cy [LANES];
	ssd_sign_t                    ln_sign [LANES];
	logic                         ln_valid [LANES];
	logic [RW-1:0]                ln_dist [LANES];

	assign ln_ax[0] = seg_b_start_x;  assign ln_ay[0] = seg_b_start_y;
	assign ln_bx[0] = seg_b_end_x;    assign ln_by[0] = seg_b_end_y;
	assign ln_cx[0] = seg_a_start_x;  assign ln_cy[0] = seg_a_start_y;
	assign ln_ax[1] = seg_b_start_x;  assign ln_ay[1] = seg_b_start_y;
	assign ln_bx[1] = seg_b_end_x;    assign ln_by[1] = seg_b_end_y;
	assign ln_cx[1] = seg_a_end_x;    assign ln_cy[1] = seg_a_end_y;
	assign ln_ax[2] = seg_a_start_x;  assign ln_ay[2] = seg_a_start_y;
	assign ln_bx[2] = seg_a_end_x;    assign ln_by[2] = seg_a_end_y;
	assign ln_cx[2] = seg_b_start_x;  assign ln_cy[2] = seg_b_start_y;
	assign ln_ax[3] = seg_a_start_x;  assign ln_ay[3] = seg_a_start_y;
	assign ln_bx[3] = seg_a_end_x;    assign ln_by[3] = seg_a_end_y;
	assign ln_cx[3] = seg_b_end_x;    assign ln_cy[3] = seg_b_end_y;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		ssd_lane #(.COORD_BITS(COORD_BITS)) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid_in (accept),
			.ax       (ln_ax[i]),
			.ay       (ln_ay[i]),
			.bx       (ln_bx[i]),
			.by       (ln_by[i]),
			.cx       (ln_cx[i]),
			.cy       (ln_cy[i]),
			.cr_sign  (ln_sign[i]),
			.valid_out(ln_valid[i]),
			.seg_dist (ln_dist[i])
		);
	end

	// proper crossing: strict opposite orientation on both segments
	logic cross_now;
	assign cross_now =
		((ln_sign[2].pos && ln_sign[3].neg) || (ln_sign[2].neg && ln_sign[3].pos)) &&
		((ln_sign[0].pos && ln_sign[1].neg) || (ln_sign[0].neg && ln_sign[1].pos));

	// carry the crossing flag alongside lane stages 3 and 4 and the divider and root stages
	logic cross_dl [CDL];

	for (genvar k = 0; k < CDL; k++) begin : g_cdl
		if (k == 0) begin : g_first
			always_ff @(posedge clk) begin
				cross_dl[k] <= cross_now;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				cross_dl[k] <= cross_dl[k-1];
			end
		end
	end

	// minimum, first level
	logic [RW-1:0] min01_s1, min23_s1;
	logic          cross_s1, valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= ln_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		min01_s1 <= (ln_dist[1] < ln_dist[0]) ? ln_dist[1] : ln_dist[0];
		min23_s1 <= (ln_dist[3] < ln_dist[2]) ? ln_dist[3] : ln_dist[2];
		cross_s1 <= cross_dl[CDL-1];
	end

	// minimum, second level, with saturation and the crossing override
	logic [RW-1:0] min_all;
	logic [WW-1:0] min_wide;

	assign min_all  = (min23_s1 < min01_s1) ? min23_s1 : min01_s1;
	assign min_wide = WW'(min_all);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		crossing <= cross_s1;
		if (cross_s1) begin
			min_distance <= '0;
		end else if (min_wide > WW'(DIST_MAX)) begin
			min_distance <= DIST_MAX;
		end else begin
			min_distance <= min_wide[DIST_W-1:0];
		end
	end

	// all lanes run in lockstep
	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		ln_valid[0] == ln_valid[1] && ln_valid[0] == ln_valid[2] &&
		ln_valid[0] == ln_valid[3])
		else $error("lane valid bits disagree");

	// a crossing result always reports zero distance
	a_cross_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && crossing |-> min_distance == '0)
		else $error("crossing item with nonzero distance");

	// a result strobe follows each lane result through the valid_s1 and done registers
	a_out_timing: assert property (@(posedge clk) disable iff (!arst_n)
		ln_valid[0] |=> ##1 done)
		else $error("result strobe missing");

endmodule
`default_nettype wire
